>>> src/assert_macros.svh
// Assertion helpers shared by the controller modules.
// Both expect signals named clock and reset in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHECK_PROP(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When cond holds, result must hold in the next cycle.
`define CHECK_NEXT(lbl, cond, result, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (result)) \
      else $error(msg);

`endif

>>> src/pidc_pkg.sv
`timescale 1ns / 1ps

package pidc_pkg;

   // Register file geometry: seven 32-bit registers at byte addresses 4*i.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_TARGET         = 3'd0,
      REG_GAIN_P         = 3'd1,
      REG_GAIN_I         = 3'd2,
      REG_GAIN_D         = 3'd3,
      REG_DRIVE_MIN      = 3'd4,
      REG_DRIVE_MAX      = 3'd5,
      REG_INTEGRAL_LIMIT = 3'd6
   } reg_index_type;

   localparam logic [15:0] TARGET_RESET    = 16'h0000;
   localparam logic [15:0] GAIN_RESET      = 16'h0000;
   localparam logic [15:0] DRIVE_MIN_RESET = 16'hFF9C;   // -100
   localparam logic [15:0] DRIVE_MAX_RESET = 16'h0064;   // +100
   localparam logic [30:0] LIMIT_RESET     = 31'h7FFF_FFFF;

   // Product widths: Q8.8 gain times error, integral and difference.
   localparam int ERR_W    = 17;
   localparam int DIFF_W   = 18;
   localparam int ACC_W    = 32;
   localparam int PROD_P_W = 16 + ERR_W;
   localparam int PROD_I_W = 16 + ACC_W;
   localparam int PROD_D_W = 16 + DIFF_W;
   localparam int SUM_W    = PROD_I_W + 2;
   localparam int FRAC_W   = 8;

   typedef struct packed {
      logic [15:0] target;
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [15:0] drive_min;
      logic [15:0] drive_max;
      logic [30:0] integral_limit;
   } cfg_type;

   // Operands handed from the integrator stage to the multiplier stage.
   typedef struct packed {
      logic [ERR_W-1:0]  err;
      logic [DIFF_W-1:0] diff;
      logic [ACC_W-1:0]  acc;
   } stage1_type;

endpackage

>>> src/pidc_csr.sv
`timescale 1ns / 1ps

module pidc_csr
   import pidc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg,
   output logic                  clear_state
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_sel;
   logic          write_en;

   assign reg_sel  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in      = cfg_ff;
      clear_state = 1'b0;
      if (write_en) begin
         case (reg_sel)
            REG_TARGET: begin
               cfg_in.target = pwdata[15:0];
            end
            REG_GAIN_P: begin
               cfg_in.gain_p = pwdata[15:0];
               clear_state   = 1'b1;
            end
            REG_GAIN_I: begin
               cfg_in.gain_i = pwdata[15:0];
               clear_state   = 1'b1;
            end
            REG_GAIN_D: begin
               cfg_in.gain_d = pwdata[15:0];
               clear_state   = 1'b1;
            end
            REG_DRIVE_MIN: begin
               cfg_in.drive_min = pwdata[15:0];
            end
            REG_DRIVE_MAX: begin
               cfg_in.drive_max = pwdata[15:0];
            end
            REG_INTEGRAL_LIMIT: begin
               cfg_in.integral_limit = pwdata[30:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Signed registers read back sign-extended.
   always_comb begin
      case (reg_sel)
         REG_TARGET:         prdata = {{16{cfg_ff.target[15]}}, cfg_ff.target};
         REG_GAIN_P:         prdata = {{16{cfg_ff.gain_p[15]}}, cfg_ff.gain_p};
         REG_GAIN_I:         prdata = {{16{cfg_ff.gain_i[15]}}, cfg_ff.gain_i};
         REG_GAIN_D:         prdata = {{16{cfg_ff.gain_d[15]}}, cfg_ff.gain_d};
         REG_DRIVE_MIN:      prdata = {{16{cfg_ff.drive_min[15]}}, cfg_ff.drive_min};
         REG_DRIVE_MAX:      prdata = {{16{cfg_ff.drive_max[15]}}, cfg_ff.drive_max};
         REG_INTEGRAL_LIMIT: prdata = {1'b0, cfg_ff.integral_limit};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target         <= TARGET_RESET;
         cfg_ff.gain_p         <= GAIN_RESET;
         cfg_ff.gain_i         <= GAIN_RESET;
         cfg_ff.gain_d         <= GAIN_RESET;
         cfg_ff.drive_min      <= DRIVE_MIN_RESET;
         cfg_ff.drive_max      <= DRIVE_MAX_RESET;
         cfg_ff.integral_limit <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/pidc_integ.sv
`timescale 1ns / 1ps

module pidc_integ
   import pidc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        clear_state,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_measurement,
   input  logic        s2_free,
   output logic        s1_valid,
   output stage1_type  s1
);

   `include "assert_macros.svh"

   logic              s1_valid_ff;
   logic              s1_valid_in;
   stage1_type        s1_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_in;
   logic [ERR_W-1:0]  prev_ff;
   logic [ERR_W-1:0]  err;
   logic [DIFF_W-1:0] diff;
   logic [ACC_W:0]    acc_sum;
   logic [ACC_W:0]    lim_pos;
   logic [ACC_W:0]    lim_neg;
   logic [ACC_W:0]    acc_clip;
   logic              s1_free;
   logic              take;
   logic signed [ACC_W-1:0] acc_s;
   logic signed [ACC_W-1:0] lim_s;

   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign take      = req_valid && s1_free;

   assign err  = {cfg.target[15], cfg.target} - {req_measurement[15], req_measurement};
   assign diff = {err[ERR_W-1], err} - {prev_ff[ERR_W-1], prev_ff};

   // Accumulate one bit wider than the state so the clamp sees the true sum.
   assign acc_sum = {acc_ff[ACC_W-1], acc_ff}
                  + {{(ACC_W+1-ERR_W){err[ERR_W-1]}}, err};
   assign lim_pos = {2'b00, cfg.integral_limit};
   assign lim_neg = -lim_pos;

   always_comb begin
      acc_clip = acc_sum;
      if ($signed(acc_clip) > $signed(lim_pos)) begin
         acc_clip = lim_pos;
      end
      if ($signed(acc_clip) < $signed(lim_neg)) begin
         acc_clip = lim_neg;
      end
      acc_in = acc_clip[ACC_W-1:0];
   end

   assign s1_valid_in = s1_free ? take : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= '0;
         prev_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (clear_state) begin
            acc_ff  <= '0;
            prev_ff <= '0;
         end else if (take) begin
            acc_ff  <= acc_in;
            prev_ff <= err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_ff.err  <= err;
         s1_ff.diff <= diff;
         s1_ff.acc  <= acc_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

   assign acc_s = $signed(acc_ff);
   assign lim_s = $signed({1'b0, cfg.integral_limit});

   `CHECK_NEXT(a_integral_bound, take && !clear_state, (acc_s <= $past(lim_s)) && (acc_s >= -$past(lim_s)), "integral left its clamp range")
   `CHECK_NEXT(a_gain_write_clears, clear_state, (acc_ff == '0) && (prev_ff == '0), "gain write did not clear the integrator")

endmodule

>>> src/pidc_mac.sv
`timescale 1ns / 1ps

module pidc_mac
   import pidc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        s1_valid,
   input  stage1_type  s1,
   output logic        s2_free,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_drive,
   output logic        rsp_saturated
);

   `include "assert_macros.svh"

   logic signed [PROD_P_W-1:0] mul_p;
   logic signed [PROD_I_W-1:0] mul_i;
   logic signed [PROD_D_W-1:0] mul_d;
   logic [PROD_P_W-1:0]        prod_p_ff;
   logic [PROD_I_W-1:0]        prod_i_ff;
   logic [PROD_D_W-1:0]        prod_d_ff;
   logic                       s2_valid_ff;
   logic                       s2_valid_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [15:0]                drive_ff;
   logic [15:0]                drive_in;
   logic                       sat_ff;
   logic                       sat_in;
   logic [SUM_W-1:0]           sum;
   logic [SUM_W-FRAC_W-1:0]    scaled;
   logic [SUM_W-FRAC_W-1:0]    dmin_ext;
   logic [SUM_W-FRAC_W-1:0]    dmax_ext;
   logic [SUM_W-FRAC_W-1:0]    clip;
   logic                       out_free;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s2_free     = !s2_valid_ff || out_free;
   assign s2_valid_in = s2_free ? s1_valid : 1'b1;
   assign rsp_valid_in = out_free ? s2_valid_ff : 1'b1;

   assign mul_p = $signed(cfg.gain_p) * $signed(s1.err);
   assign mul_i = $signed(cfg.gain_i) * $signed(s1.acc);
   assign mul_d = $signed(cfg.gain_d) * $signed(s1.diff);

   // Exact sum, then drop the Q8.8 fraction: an arithmetic shift floors.
   assign sum = {{(SUM_W-PROD_P_W){prod_p_ff[PROD_P_W-1]}}, prod_p_ff}
              + {{(SUM_W-PROD_I_W){prod_i_ff[PROD_I_W-1]}}, prod_i_ff}
              + {{(SUM_W-PROD_D_W){prod_d_ff[PROD_D_W-1]}}, prod_d_ff};
   assign scaled   = sum[SUM_W-1:FRAC_W];
   assign dmin_ext = {{(SUM_W-FRAC_W-16){cfg.drive_min[15]}}, cfg.drive_min};
   assign dmax_ext = {{(SUM_W-FRAC_W-16){cfg.drive_max[15]}}, cfg.drive_max};

   // Upper clip first, then lower, so an inverted pair settles on drive_min.
   always_comb begin
      clip   = scaled;
      sat_in = 1'b0;
      if ($signed(clip) > $signed(dmax_ext)) begin
         clip   = dmax_ext;
         sat_in = 1'b1;
      end
      if ($signed(clip) < $signed(dmin_ext)) begin
         clip   = dmin_ext;
         sat_in = 1'b1;
      end
      drive_in = clip[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid && s2_free) begin
         prod_p_ff <= mul_p;
         prod_i_ff <= mul_i;
         prod_d_ff <= mul_d;
      end
      if (s2_valid_ff && out_free) begin
         drive_ff <= drive_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = drive_ff;
   assign rsp_saturated = sat_ff;

   `CHECK_NEXT(a_product_reaches_output, s2_valid_ff && out_free, rsp_valid_ff, "product word was lost before the output register")

endmodule

>>> src/pid_controller_clamped.sv
`timescale 1ns / 1ps
// A word accepted at the input passes the operand, product and output registers in turn.
// Throughput: one word per cycle unless stalled, set by the combinational integral clamp.
// Reset is synchronous and active high: it clears the integral, the previous error and
// the pipeline valid flags, and loads the register defaults (drive limits -100 and +100,
// integral limit 2^31-1, target and gains zero).

module pid_controller_clamped
   import pidc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [15:0]           req_measurement,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_drive,
   output logic                  rsp_saturated,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   logic       clear_state;
   logic       s1_valid;
   stage1_type s1;
   logic       s2_free;

   // Register file. A write to any of the three gains also clears the
   // controller state, so that a retuned loop starts from a clean integral.
   pidc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .cfg         (cfg),
      .clear_state (clear_state)
   );

   // First stage. On accepting a word it forms the error and the difference
   // from the previous error, updates the clamped integral in the same cycle,
   // and registers all three operands. Integral and previous error are the only
   // feedback paths, so a new word can follow in the very next cycle unless stalled.
   pidc_integ u_integ (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .clear_state     (clear_state),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_measurement (req_measurement),
      .s2_free         (s2_free),
      .s1_valid        (s1_valid),
      .s1              (s1)
   );

   // Second and third stages. The three gain products are registered, then
   // summed, floored by the Q8.8 fraction and saturated into the output
   // register. Each stage moves on whenever the one after it is empty or is
   // itself moving, so a stall on the result side ripples back one stage at a
   // time and no word is dropped or repeated.
   pidc_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .s1_valid      (s1_valid),
      .s1            (s1),
      .s2_free       (s2_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_drive     (rsp_drive),
      .rsp_saturated (rsp_saturated)
   );

endmodule

>>> tb/sv/pid_drive_checker.sv
`timescale 1ns / 1ps

module pid_drive_checker
   import pidc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [15:0]           req_measurement,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [15:0]           rsp_drive,
   input  logic                  rsp_saturated,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    failures,
   output int                    outstanding,
   output int                    drives_checked,
   output int                    clips_seen
);

   typedef struct packed {
      logic [15:0] drive;
      logic        saturated;
   } drive_word_type;

   // Shadow copy of the register file and of the controller state.
   logic signed [15:0] set_point;
   logic signed [15:0] kp;
   logic signed [15:0] ki;
   logic signed [15:0] kd;
   logic signed [15:0] drive_lo;
   logic signed [15:0] drive_hi;
   logic [30:0]        integral_cap;
   longint             integral;
   longint             last_error;

   drive_word_type expected_drives[$];

   function automatic drive_word_type predict_drive(input logic [15:0] meas);
      longint         err;
      longint         diff;
      longint         acc;
      longint         cap;
      longint         total;
      longint         y;
      drive_word_type word;
      err = longint'(set_point) - longint'($signed(meas));
      diff = err - last_error;
      last_error = err;
      cap = integral_cap;
      acc = integral + err;
      if (acc > cap) acc = cap;
      if (acc < -cap) acc = -cap;
      integral = acc;
      total = longint'(kp) * err + longint'(ki) * acc + longint'(kd) * diff;
      // Arithmetic shift of a signed value rounds towards minus infinity.
      y = total >>> 8;
      word.saturated = 1'b0;
      if (y > longint'(drive_hi)) begin
         y = drive_hi;
         word.saturated = 1'b1;
      end
      if (y < longint'(drive_lo)) begin
         y = drive_lo;
         word.saturated = 1'b1;
      end
      word.drive = y[15:0];
      return word;
   endfunction

   always @(posedge clock) begin
      drive_word_type want;
      if (reset) begin
         set_point = TARGET_RESET;
         kp = GAIN_RESET;
         ki = GAIN_RESET;
         kd = GAIN_RESET;
         drive_lo = DRIVE_MIN_RESET;
         drive_hi = DRIVE_MAX_RESET;
         integral_cap = LIMIT_RESET;
         integral = 0;
         last_error = 0;
         expected_drives.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            drives_checked++;
            if (expected_drives.size() == 0) begin
               $error("drive word %0d arrived with nothing expected", $signed(rsp_drive));
               failures++;
            end else begin
               want = expected_drives.pop_front();
               if (want.saturated) clips_seen++;
               if (rsp_drive !== want.drive) begin
                  $error("drive: expected %0d, got %0d", $signed(want.drive),
                         $signed(rsp_drive));
                  failures++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %0b, got %0b", want.saturated, rsp_saturated);
                  failures++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_TARGET: set_point = pwdata[15:0];
               REG_GAIN_P: begin
                  kp = pwdata[15:0];
                  integral = 0;
                  last_error = 0;
               end
               REG_GAIN_I: begin
                  ki = pwdata[15:0];
                  integral = 0;
                  last_error = 0;
               end
               REG_GAIN_D: begin
                  kd = pwdata[15:0];
                  integral = 0;
                  last_error = 0;
               end
               REG_DRIVE_MIN: drive_lo = pwdata[15:0];
               REG_DRIVE_MAX: drive_hi = pwdata[15:0];
               REG_INTEGRAL_LIMIT: integral_cap = pwdata[30:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_drives.push_back(predict_drive(req_measurement));
         outstanding = expected_drives.size();
      end
   end

endmodule

>>> tb/sv/pid_controller_clamped_test.sv
`timescale 1ns / 1ps

module pid_controller_clamped_test;
   import pidc_pkg::*;

   // Address slot beyond the register file; a write there must change nothing.
   localparam logic [2:0] REG_UNUSED = 3'd7;
   // Length of the receiver's deliberate hold-off, in clock cycles.
   localparam int HOLD_CYCLES = 80;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [15:0]           req_measurement = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [15:0]           rsp_drive;
   logic                  rsp_saturated;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int failures;
   int outstanding;
   int drives_checked;
   int clips_seen;
   int settings = 0;

   // Flags shared between the stimulus and the receiver process. When a side is
   // calm it never idles; hold_start asks the receiver for one long hold-off.
   bit send_calm = 1'b0;
   bit take_calm = 1'b0;
   bit hold_start = 1'b0;
   int hold_left = 0;

   always #6 clock = ~clock;

   pid_controller_clamped dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive       (rsp_drive),
      .rsp_saturated   (rsp_saturated),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   pid_drive_checker drive_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive       (rsp_drive),
      .rsp_saturated   (rsp_saturated),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .failures        (failures),
      .outstanding     (outstanding),
      .drives_checked  (drives_checked),
      .clips_seen      (clips_seen)
   );

   // Receiver. Every falling edge it decides whether to stall the next result
   // word. A requested hold-off is counted down here, so the sender carries on
   // offering words while the pipeline fills behind the held result port.
   always @(negedge clock) begin
      if (hold_start) begin
         hold_start = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (take_calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 26);
      end
   end

   // Safety net: far longer than the slowest correct run could take.
   initial begin
      #(12 * 250_000);
      $display("pid_controller_clamped_test NOT OK");
      $finish;
   end

   // One register write: a setup phase, then an access phase held until pready.
   // The bits above each register's width carry random junk, which the block
   // has to ignore.
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] junk;
      junk = $urandom;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= (idx == REG_INTEGRAL_LIMIT) ? {junk[0], value[30:0]}
                                            : {junk[15:0], value[15:0]};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // Offers one measurement word, after a random number of idle cycles unless
   // the sender is calm, and holds it steady until the block takes it.
   task automatic send_word(input logic [15:0] m);
      while (!send_calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_measurement <= m;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Lets the pipeline drain so that registers may be written safely: it waits until
   // every drive word in the block's three stages has come out and been checked.
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         2, 3: return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 1023)) - 512);
      endcase
   endfunction

   initial begin
      int          n_items;
      int          pick;
      int          lo_v;
      int          hi_v;
      int          swap;
      int          near;
      int          cur_target;
      logic [15:0] m;

      cur_target = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With the reset settings all gains are zero, so the drive must be zero
      // and unclipped whatever the measurement is.
      send_word(16'h8000);
      send_word(16'h7FFF);
      settle();
      settings++;

      // Extreme target, gains and drive limits. Alternating full-scale samples
      // give the widest positive error and the widest difference in both directions,
      // and the integral heads for its full 32-bit range.
      write_reg(REG_TARGET, 32767);
      write_reg(REG_GAIN_P, 32767);
      write_reg(REG_GAIN_I, -32768);
      write_reg(REG_GAIN_D, 32767);
      write_reg(REG_DRIVE_MIN, -32768);
      write_reg(REG_DRIVE_MAX, 32767);
      send_word(16'h8000);
      send_word(16'h7FFF);
      send_word(16'h8000);
      send_word(16'h0000);
      send_word(16'h7FFF);
      settle();
      settings++;

      // A zero integral limit pins the integral at zero, even for the largest
      // negative error.
      write_reg(REG_INTEGRAL_LIMIT, 0);
      write_reg(REG_TARGET, -32768);
      write_reg(REG_GAIN_P, 256);
      write_reg(REG_GAIN_I, 256);
      write_reg(REG_GAIN_D, 0);
      send_word(16'h7FFF);
      send_word(16'h0000);
      settle();
      settings++;

      // Raising the limit is not a gain write, so the state carries on; the
      // repeated small negative error then runs into the lower bound.
      write_reg(REG_INTEGRAL_LIMIT, 10);
      repeat (3) send_word(16'h8008);
      settle();
      settings++;

      // A gain of one LSB turns an error of -1 into a sum of -1, which has to
      // round down to -1 rather than towards zero.
      write_reg(REG_TARGET, 0);
      write_reg(REG_GAIN_P, 1);
      write_reg(REG_GAIN_I, 0);
      send_word(16'h0001);
      send_word(16'hFFFF);
      settle();
      settings++;

      // Inverted drive limits: the lower limit wins and the word is flagged as
      // saturated. A write to the empty address slot must leave all of it alone.
      write_reg(REG_GAIN_P, 256);
      write_reg(REG_DRIVE_MIN, 50);
      write_reg(REG_DRIVE_MAX, -50);
      send_word(16'h0000);
      send_word(16'hFC18);
      settle();
      write_reg(REG_UNUSED, $urandom);
      send_word(16'h0000);
      settle();
      settings++;

      // Random part: twelve register settings, each followed by a batch of
      // measurements. The fourth batch runs with no idling on either side; the
      // seventh keeps the sender busy while the receiver holds off for a long
      // stretch, so the block backs up and stalls its input.
      for (int batch = 0; batch < 12; batch++) begin
         send_calm = (batch == 3) || (batch == 6);
         take_calm = (batch == 3);

         if (batch == 0 || $urandom_range(0, 99) < 70) begin
            if ($urandom_range(0, 1))
               cur_target = int'($urandom_range(0, 4000)) - 2000;
            else
               cur_target = int'($urandom_range(0, 65535)) - 32768;
            write_reg(REG_TARGET, cur_target);
         end
         if (batch == 0 || $urandom_range(0, 99) < 70) write_reg(REG_GAIN_P, pick_gain());
         if (batch == 0 || $urandom_range(0, 99) < 70) write_reg(REG_GAIN_I, pick_gain());
         if (batch == 0 || $urandom_range(0, 99) < 70) write_reg(REG_GAIN_D, pick_gain());

         if (batch == 0 || $urandom_range(0, 99) < 70) begin
            // Mostly an ordered window, sometimes a narrow one, now and then
            // an inverted pair or the full 16-bit range.
            pick = $urandom_range(0, 99);
            lo_v = int'($urandom_range(0, 65535)) - 32768;
            hi_v = int'($urandom_range(0, 65535)) - 32768;
            if (pick < 50) begin
               lo_v = lo_v / 64;
               hi_v = hi_v / 64;
            end
            if ((lo_v > hi_v) != (pick < 15)) begin
               swap = lo_v;
               lo_v = hi_v;
               hi_v = swap;
            end
            if (pick >= 95) begin
               lo_v = -32768;
               hi_v = 32767;
            end
            write_reg(REG_DRIVE_MIN, lo_v);
            write_reg(REG_DRIVE_MAX, hi_v);
         end

         if (batch == 0 || $urandom_range(0, 99) < 70) begin
            case ($urandom_range(0, 3))
               0: write_reg(REG_INTEGRAL_LIMIT, 0);
               1: write_reg(REG_INTEGRAL_LIMIT, $urandom_range(1, 2000));
               2: write_reg(REG_INTEGRAL_LIMIT, $urandom & 32'h7FFF_FFFF);
               default: write_reg(REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
            endcase
         end

         if (batch == 6) hold_start = 1'b1;

         // Most samples sit near the set point, where the loop behaves like a
         // controller; the rest span the full measurement range.
         n_items = $urandom_range(100, 130);
         repeat (n_items) begin
            if ($urandom_range(0, 99) < 70) begin
               near = cur_target + int'($urandom_range(0, 600)) - 300;
               if (near > 32767) near = 32767;
               if (near < -32768) near = -32768;
               m = near[15:0];
            end else begin
               m = $urandom;
            end
            send_word(m);
         end
         settle();
         settings++;
      end

      repeat (10) @(negedge clock);

      $display("Checked %0d drive words over %0d register settings, %0d of them clipped.",
               drives_checked, settings, clips_seen);
      $display("Both sides idled at random, with one calm batch and one %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (failures == 0 && outstanding == 0)
         $display("pid_controller_clamped_test OK");
      else
         $display("pid_controller_clamped_test NOT OK");
      $finish;
   end

endmodule
